// File: design/fcta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcta_pkg
// Shared constants, types and the fixed-point readout scale for the
// four-channel two-stage averager.
// ----------------------------------------------------------------------------
package fcta_pkg;

    localparam int NUM_CH    = 4;
    localparam int CH_W      = $clog2(NUM_CH);
    localparam int SMP_W     = 10;
    localparam int SEL_W     = 3;
    localparam int MV_W      = 13;

    // Averaging depth: rounds per block and blocks per ring.
    localparam int BLOCK_LEN = 8;
    localparam int RING_LEN  = 8;

    localparam longint unsigned FULL_CODE = 1023;
    localparam longint unsigned FULL_MV   = 5000;

    localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam int POS_W = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
    localparam int ACC_W = $clog2(FULL_CODE * BLOCK_LEN + 1);

    // Divisor of the mean; also the largest possible ring total.
    localparam longint unsigned DEN = FULL_CODE * BLOCK_LEN * RING_LEN;
    localparam int TOT_W  = $clog2(DEN + 1);

    // total*5000 / DEN as a multiply by a rounded-up reciprocal. With
    // shift S = P_W + ceil(log2 DEN) the floor comes out exact.
    localparam int P_W    = $clog2(DEN * FULL_MV + 1);
    localparam int DEN_LG = $clog2(DEN);
    localparam int SHIFT  = P_W + DEN_LG;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DEN - 1) / DEN;
    localparam int M_W    = P_W + 2;
    localparam int PM_W   = P_W + M_W;
    localparam logic [M_W-1:0]  RECIP_M  = M_W'(RECIP);
    localparam logic [P_W-1:0]  SCALE_MV = P_W'(FULL_MV);
    localparam logic [MV_W-1:0] MAX_MV   = MV_W'(FULL_MV);

    // Queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        CMD_SAMPLE    = 1'b0,
        CMD_READ_ONLY = 1'b1
    } t_cmd;

    // One classified request as it travels from front to back.
    typedef struct packed {
        logic                              read_only;
        logic                              sel_ok;
        logic [CH_W-1:0]                   sel_idx;
        logic [NUM_CH-1:0][SMP_W-1:0]      samples;
    } t_item;

endpackage

// File: design/fcta_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcta_front
// Input stage: takes a request, decodes command and select, and hands the
// classified item to the queue.
// ----------------------------------------------------------------------------
module fcta_front
    import fcta_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [SMP_W-1:0]   i_sample_ch0,
    input  logic [SMP_W-1:0]   i_sample_ch1,
    input  logic [SMP_W-1:0]   i_sample_ch2,
    input  logic [SMP_W-1:0]   i_sample_ch3,
    input  logic [SEL_W-1:0]   i_sensor_select,
    output logic               o_q_valid,
    input  logic               i_q_ready,
    output t_item              o_q_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item.read_only  = (t_cmd'(i_cmd) == CMD_READ_ONLY);
        n_item.sel_ok     = (i_sensor_select < SEL_W'(NUM_CH));
        n_item.sel_idx    = i_sensor_select[CH_W-1:0];
        n_item.samples[0] = i_sample_ch0;
        n_item.samples[1] = i_sample_ch1;
        n_item.samples[2] = i_sample_ch2;
        n_item.samples[3] = i_sample_ch3;
    end

    assign o_ready   = !r_valid || i_q_ready;
    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// File: design/fcta_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcta_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module fcta_queue
    import fcta_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_valid,
    output t_item  o_item
);

    t_item            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr;
    logic [Q_AW-1:0]  r_rd;
    logic [Q_CW-1:0]  r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_ready = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + Q_CW'(i_push) - Q_CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// File: design/fcta_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcta_back
// Block/ring update as each item is popped, then a three-stage readout that
// scales the selected ring total to millivolts.
// ----------------------------------------------------------------------------
module fcta_back
    import fcta_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_item             i_q_item,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [MV_W-1:0]   o_selected_mv,
    output logic              o_ring_updated
);

    // Averaging state
    logic [ACC_W-1:0] r_acc  [NUM_CH];
    logic [ACC_W-1:0] n_acc  [NUM_CH];
    logic [TOT_W-1:0] r_tot  [NUM_CH];
    logic [TOT_W-1:0] n_tot  [NUM_CH];
    logic [ACC_W-1:0] r_ring [NUM_CH][RING_LEN];
    logic [ACC_W-1:0] acc_sum [NUM_CH];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             block_done;
    logic             ring_wr;

    // Readout pipeline
    logic             r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic             r_s1_upd,   r_s2_upd,   r_s3_upd,   r_s4_upd;
    logic [TOT_W-1:0] r_s1_tot;
    logic [P_W-1:0]   r_s2_p;
    logic [PM_W-1:0]  r_s3_prod;
    logic [MV_W-1:0]  r_s4_mv;
    logic             s1_rdy, s2_rdy, s3_rdy, s4_rdy;
    logic [PM_W-SHIFT-1:0] quot;
    logic [MV_W-1:0]  mv_clamped;

    assign s4_rdy  = !r_s4_valid || i_ready;
    assign s3_rdy  = !r_s3_valid || s4_rdy;
    assign s2_rdy  = !r_s2_valid || s3_rdy;
    assign s1_rdy  = !r_s1_valid || s2_rdy;
    assign o_q_pop = i_q_valid && s1_rdy;

    assign block_done = (r_cnt == CNT_W'(BLOCK_LEN - 1));
    assign ring_wr    = !i_q_item.read_only && block_done;

    always_comb begin
        n_cnt = r_cnt;
        n_pos = r_pos;
        for (int c = 0; c < NUM_CH; c++) begin
            acc_sum[c] = r_acc[c] + ACC_W'(i_q_item.samples[c]);
            n_acc[c]   = r_acc[c];
            n_tot[c]   = r_tot[c];
        end
        if (!i_q_item.read_only) begin
            if (block_done) begin
                n_cnt = '0;
                n_pos = (r_pos == POS_W'(RING_LEN - 1)) ? '0 : r_pos + 1'b1;
                for (int c = 0; c < NUM_CH; c++) begin
                    n_acc[c] = '0;
                    n_tot[c] = r_tot[c] - TOT_W'(r_ring[c][r_pos]) + TOT_W'(acc_sum[c]);
                end
            end else begin
                n_cnt = r_cnt + 1'b1;
                for (int c = 0; c < NUM_CH; c++) begin
                    n_acc[c] = acc_sum[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pos <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_acc[c] <= '0;
                r_tot[c] <= '0;
                for (int p = 0; p < RING_LEN; p++) begin
                    r_ring[c][p] <= '0;
                end
            end
        end else if (o_q_pop) begin
            r_cnt <= n_cnt;
            r_pos <= n_pos;
            for (int c = 0; c < NUM_CH; c++) begin
                r_acc[c] <= n_acc[c];
                r_tot[c] <= n_tot[c];
                if (ring_wr) begin
                    r_ring[c][r_pos] <= acc_sum[c];
                end
            end
        end
    end

    // Valid bits of the readout stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (s1_rdy) r_s1_valid <= i_q_valid;
            if (s2_rdy) r_s2_valid <= r_s1_valid;
            if (s3_rdy) r_s3_valid <= r_s2_valid;
            if (s4_rdy) r_s4_valid <= r_s3_valid;
        end
    end

    // Out-of-range select forces a zero total, which reads as 0 mV.
    assign quot       = r_s3_prod[PM_W-1:SHIFT];
    assign mv_clamped = (quot > (PM_W-SHIFT)'(MAX_MV)) ? MAX_MV : quot[MV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_tot <= i_q_item.sel_ok ? n_tot[i_q_item.sel_idx] : '0;
            r_s1_upd <= ring_wr;
        end
        if (s2_rdy && r_s1_valid) begin
            r_s2_p   <= P_W'(r_s1_tot) * SCALE_MV;
            r_s2_upd <= r_s1_upd;
        end
        if (s3_rdy && r_s2_valid) begin
            r_s3_prod <= PM_W'(r_s2_p) * PM_W'(RECIP_M);
            r_s3_upd  <= r_s2_upd;
        end
        if (s4_rdy && r_s3_valid) begin
            r_s4_mv  <= mv_clamped;
            r_s4_upd <= r_s3_upd;
        end
    end

    assign o_valid        = r_s4_valid;
    assign o_selected_mv  = r_s4_mv;
    assign o_ring_updated = r_s4_upd;

endmodule

// File: design/four_channel_two_stage_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_two_stage_averager
// Block average of four range channels followed by a moving sum over the
// last RING_LEN blocks; reports the selected channel's mean in millivolts.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+---------------------------------
//  request  | in        | i_valid / o_ready   | i_cmd, i_sample_ch0..3,
//           |           |                     | i_sensor_select
//  result   | out       | o_valid / i_ready   | o_selected_mv, o_ring_updated
//
//  Throughput: one request per cycle while the result path does not stall;
//  each request yields exactly one result.
//  Path: a request passes the input register, then the queue, update stage,
//  two multiply stages and the output register before its result is valid.
//  Reset (i_rst_n low, synchronous) zeroes accumulators, totals and ring.
//  Front and back stall independently: the 2-entry queue absorbs a stalled
//  result path while the input register keeps taking requests.
// ----------------------------------------------------------------------------
module four_channel_two_stage_averager
    import fcta_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [SMP_W-1:0]   i_sample_ch0,
    input  logic [SMP_W-1:0]   i_sample_ch1,
    input  logic [SMP_W-1:0]   i_sample_ch2,
    input  logic [SMP_W-1:0]   i_sample_ch3,
    input  logic [SEL_W-1:0]   i_sensor_select,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [MV_W-1:0]    o_selected_mv,
    output logic               o_ring_updated
);

    // front -> queue
    logic  fr_valid;
    logic  q_ready;
    t_item fr_item;
    // queue -> back
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    // Front: registers the request and decodes command and select.
    fcta_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_sample_ch0    (i_sample_ch0),
        .i_sample_ch1    (i_sample_ch1),
        .i_sample_ch2    (i_sample_ch2),
        .i_sample_ch3    (i_sample_ch3),
        .i_sensor_select (i_sensor_select),
        .o_q_valid       (fr_valid),
        .i_q_ready       (q_ready),
        .o_q_item        (fr_item)
    );

    // Decoupling queue; push whenever the front holds an item and there is room.
    fcta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid && q_ready),
        .i_item  (fr_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back: state update on pop, then the millivolt readout pipeline.
    fcta_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_selected_mv  (o_selected_mv),
        .o_ring_updated (o_ring_updated)
    );

endmodule

// File: design/fcta_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcta_checker
// Port-level checks of the averager, bound to the top level.
// ----------------------------------------------------------------------------
module fcta_checker
    import fcta_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic               i_cmd,
    input  logic [SMP_W-1:0]   i_sample_ch0,
    input  logic [SMP_W-1:0]   i_sample_ch1,
    input  logic [SMP_W-1:0]   i_sample_ch2,
    input  logic [SMP_W-1:0]   i_sample_ch3,
    input  logic [SEL_W-1:0]   i_sensor_select,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [MV_W-1:0]    o_selected_mv,
    input  logic               o_ring_updated
);

    // Nothing comes out in the cycle after a reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // The mean never exceeds full scale.
    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_selected_mv <= MAX_MV))
        else $error("selected_mv above full scale");

    // A stalled result stays up.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_selected_mv) && $stable(o_ring_updated))
        else $error("result payload changed while stalled");

    // A waiting request stays up with its payload unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_cmd)
            && $stable(i_sample_ch0) && $stable(i_sample_ch1)
            && $stable(i_sample_ch2) && $stable(i_sample_ch3)
            && $stable(i_sensor_select))
        else $error("request changed while waiting");

endmodule

bind four_channel_two_stage_averager fcta_checker u_fcta_checker (.*);
